// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/rtfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtfc_pkg: shared types and constants of the region table fault classifier
// Field widths, mode and status codes, and controller/datapath command types.
// ----------------------------------------------------------------------------
package rtfc_pkg;

  localparam int Entries    = 64;
  localparam int SlotW      = 6;
  localparam int CountW     = 7;
  localparam int PageShift  = 12;
  localparam int AddrW      = 48;
  localparam int InodeW     = 32;

  // input field widths packed into tdata
  localparam int InDataW  = 3 + 48 + 48 + 3 + 2 + 32 + 48 + 6 + 48 + 1;   // 239
  localparam int InTdataW = 240;
  localparam int OutDataW  = 4 + 6 + 48 + 3 + 2 + 32 + 48 + 8 + 4 + 7 + 7; // 169
  localparam int OutTdataW = 176;

  localparam logic [2:0] ModeAdd    = 3'd0;
  localparam logic [2:0] ModeRmSlot = 3'd1;
  localparam logic [2:0] ModeRmRng  = 3'd2;
  localparam logic [2:0] ModeClear  = 3'd3;
  localparam logic [2:0] ModeFault  = 3'd4;

  localparam logic [3:0] StHandled   = 4'd0;
  localparam logic [3:0] StGrown     = 4'd1;
  localparam logic [3:0] StUnhandled = 4'd2;
  localparam logic [3:0] StAdded     = 4'd3;
  localparam logic [3:0] StRejected  = 4'd4;
  localparam logic [3:0] StFull      = 4'd5;
  localparam logic [3:0] StRemoved   = 4'd6;
  localparam logic [3:0] StNotFound  = 4'd7;
  localparam logic [3:0] StCleared   = 4'd8;

  localparam logic [1:0] KindAnon  = 2'd0;
  localparam logic [1:0] KindFile  = 2'd1;
  localparam logic [1:0] KindStack = 2'd2;
  localparam logic [1:0] KindGuard = 2'd3;

  localparam logic [1:0] CfgMaxStack = 2'd0;
  localparam logic [1:0] CfgGrowPg   = 2'd1;
  localparam logic [1:0] CfgMinStack = 2'd2;
  localparam logic [1:0] CfgPrefault = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [47:0] start_addr;
    logic [47:0] end_addr;
    logic [2:0]  prot_in;
    logic [1:0]  kind_in;
    logic [31:0] inode_in;
    logic [47:0] foff_in;
    logic [5:0]  slot;
    logic [47:0] flt_addr;
    logic        wr_access;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  slot_out;
    logic [47:0] map_page;
    logic [2:0]  prot_out;
    logic [1:0]  kind_out;
    logic [31:0] file_inode_out;
    logic [47:0] file_pos_out;
    logic [7:0]  grow_pages;
    logic [3:0]  prefault_count;
    logic [6:0]  removed_count;
    logic [6:0]  region_count_out;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture accepted item, reset scan state
    logic scan;     // evaluate entry at scan index, advance
    logic rd;       // present scan index to memory read
    logic finish;   // compute result and commit table update
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan index is at the final entry
  } dp_sts_t;

endpackage

// ===== design/region_table_fault_classifier.sv =====
// ----------------------------------------------------------------------------
// region_table_fault_classifier: region table with page fault classification
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command (add, remove slot, remove range, clear, fault)
//   per transfer; m_axis returns exactly one result per command.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while the block is idle.
// Sequencing:
//   Every command walks all 64 table entries, one per cycle, through the
//   region memory's single read port: after the input transfer come a
//   read-priming step, the scan of all entries and a finishing step, and
//   only one item is in flight at a time, so a new item is taken only after
//   the previous result has been accepted on m_axis.
// Reset:
//   All regions become invalid and the region count is zero; configuration
//   returns to its defaults. No clearing pass is needed.
// Stall:
//   The result is held in an output register until m_axis_tready; no new
//   command is taken until then.
// ----------------------------------------------------------------------------
module region_table_fault_classifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode, start_addr, end_addr, prot_in, kind_in, inode_in, foff_in,
  // slot, flt_addr, wr_access (lowest bit up), zero filled
  input  logic [239:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, slot_out, map_page, prot_out, kind_out, file_inode_out,
  // file_pos_out, grow_pages, prefault_count, removed_count,
  // region_count_out (lowest bit up), zero filled
  output logic [175:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [47:0]  cfg_data_i
);

  rtfc_pkg::item_t   item;
  rtfc_pkg::result_t res;
  rtfc_pkg::dp_cmd_t cmd;
  rtfc_pkg::dp_sts_t sts;

  // unpack input, first field in the lowest bits
  assign item.mode        = s_axis_tdata[2:0];
  assign item.start_addr  = s_axis_tdata[50:3];
  assign item.end_addr    = s_axis_tdata[98:51];
  assign item.prot_in     = s_axis_tdata[101:99];
  assign item.kind_in     = s_axis_tdata[103:102];
  assign item.inode_in    = s_axis_tdata[135:104];
  assign item.foff_in     = s_axis_tdata[183:136];
  assign item.slot        = s_axis_tdata[189:184];
  assign item.flt_addr    = s_axis_tdata[237:190];
  assign item.wr_access   = s_axis_tdata[238];

  // pack output
  assign m_axis_tdata = {7'd0, res.region_count_out, res.removed_count,
                         res.prefault_count, res.grow_pages, res.file_pos_out,
                         res.file_inode_out, res.kind_out, res.prot_out,
                         res.map_page, res.slot_out, res.status};

  rtfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rtfc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res)
  );

endmodule

// ===== design/rtfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtfc_ctrl: sequencer of the region table fault classifier
// Accepts one item, walks all table entries once, then finishes and holds the
// result until the output transfer completes.
// ----------------------------------------------------------------------------
module rtfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rtfc_pkg::dp_sts_t sts_i,
  output rtfc_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PRIME, S_SCAN, S_FINISH, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.rd   = 1'b1;
        if (sts_i.scan_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/rtfc_dp.sv =====
// ----------------------------------------------------------------------------
// rtfc_dp: datapath of the region table fault classifier
// Holds the region memory, valid bits, count and configuration; scans one
// entry per cycle and applies the table update at the end of the walk.
// ----------------------------------------------------------------------------
module rtfc_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rtfc_pkg::item_t       item_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [47:0]           cfg_data_i,
  input  rtfc_pkg::dp_cmd_t     cmd_i,
  output rtfc_pkg::dp_sts_t     sts_o,
  output rtfc_pkg::result_t     res_o
);

  localparam int AW = rtfc_pkg::AddrW;
  localparam int SW = rtfc_pkg::SlotW;
  localparam int PS = rtfc_pkg::PageShift;

  typedef struct packed {
    logic [AW-1:0] rstart;
    logic [AW-1:0] rend;
    logic [2:0]    prot;
    logic [1:0]    kind;
    logic [31:0]   inode;
    logic [AW-1:0] foff;
  } entry_t;

  // region memory (one write port, one registered read port)
  entry_t mem_q [rtfc_pkg::Entries];
  entry_t rd_q;
  logic   mem_we;
  logic [SW-1:0] mem_waddr;
  entry_t mem_wdata;
  logic [SW-1:0] rd_addr;

  logic [rtfc_pkg::Entries-1:0] valid_q, valid_d;
  logic [6:0] count_q, count_d;

  logic [AW-1:0] max_stack_q, min_stack_q;
  logic [7:0]    grow_win_q;
  logic [3:0]    pf_limit_q;

  rtfc_pkg::item_t it_q;
  // scan state
  logic [SW-1:0] rd_idx_q;    // address sent to memory
  logic [SW-1:0] ev_idx_q;    // entry whose data is in rd_q
  logic          hit_q, best_q, ovl_q, free_q;
  logic [SW-1:0] hit_slot_q, best_slot_q, free_slot_q;
  entry_t        hit_e_q, best_e_q;
  logic [rtfc_pkg::Entries-1:0] rm_mask_q;
  logic [6:0]    rm_cnt_q;
  logic [AW-1:0] window_q;
  logic [AW-1:0] page_q;

  rtfc_pkg::result_t res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[rd_addr];
  end

  assign rd_addr = rd_idx_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_stack_q <= AW'(8388608);
      grow_win_q  <= 8'd16;
      min_stack_q <= AW'(4096);
      pf_limit_q  <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtfc_pkg::CfgMaxStack: max_stack_q <= cfg_data_i;
        rtfc_pkg::CfgGrowPg:   grow_win_q  <= cfg_data_i[7:0];
        rtfc_pkg::CfgMinStack: min_stack_q <= cfg_data_i;
        rtfc_pkg::CfgPrefault: pf_limit_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // per-entry evaluation of the entry in rd_q
  logic ev_valid, in_hit, stk_cand, ovl_e, rng_rm;
  logic [AW-1:0] lo_e;
  always_comb begin
    ev_valid = valid_q[ev_idx_q];
    in_hit   = ev_valid && rd_q.rstart <= it_q.flt_addr && it_q.flt_addr < rd_q.rend;
    lo_e     = (rd_q.rstart >= window_q) ? rd_q.rstart - window_q : '0;
    stk_cand = ev_valid && rd_q.kind == rtfc_pkg::KindStack &&
               it_q.flt_addr >= lo_e && it_q.flt_addr < rd_q.rstart;
    ovl_e    = ev_valid && it_q.start_addr < rd_q.rend && rd_q.rstart < it_q.end_addr;
    rng_rm   = ovl_e;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q      <= item_i;
      rd_idx_q  <= '0;
      ev_idx_q  <= '0;
      hit_q     <= 1'b0;
      best_q    <= 1'b0;
      ovl_q     <= 1'b0;
      free_q    <= 1'b0;
      rm_mask_q <= '0;
      rm_cnt_q  <= '0;
      window_q  <= AW'({grow_win_q, {PS{1'b0}}});
      page_q    <= {item_i.flt_addr[AW-1:PS], {PS{1'b0}}};
    end else begin
      if (cmd_i.rd) rd_idx_q <= rd_idx_q + 1'b1;
      if (cmd_i.scan) begin
        ev_idx_q <= ev_idx_q + 1'b1;
        if (in_hit && !hit_q) begin
          hit_q <= 1'b1; hit_slot_q <= ev_idx_q; hit_e_q <= rd_q;
        end
        if (stk_cand && (!best_q || rd_q.rstart < best_e_q.rstart)) begin
          best_q <= 1'b1; best_slot_q <= ev_idx_q; best_e_q <= rd_q;
        end
        if (ovl_e) ovl_q <= 1'b1;
        if (!ev_valid && !free_q) begin
          free_q <= 1'b1; free_slot_q <= ev_idx_q;
        end
        if (rng_rm) begin
          rm_mask_q[ev_idx_q] <= 1'b1;
          rm_cnt_q <= rm_cnt_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.scan_last = (ev_idx_q == SW'(rtfc_pkg::Entries - 1));

  // finishing step: result and commit
  rtfc_pkg::result_t r;
  logic [AW-1:0] span, grow_sz, after, fpos;
  logic          aligned, add_ok;
  always_comb begin
    r         = '0;
    valid_d   = valid_q;
    count_d   = count_q;
    mem_we    = 1'b0;
    mem_waddr = free_slot_q;
    mem_wdata = '0;
    aligned   = it_q.start_addr[PS-1:0] == '0 && it_q.end_addr[PS-1:0] == '0 &&
                it_q.start_addr < it_q.end_addr;
    add_ok    = aligned && !ovl_q && free_q;
    grow_sz   = best_e_q.rend - page_q;
    span      = hit_e_q.rend - page_q;
    after     = AW'(span >> PS);
    after     = (after != '0) ? after - 1'b1 : '0;
    fpos      = hit_e_q.foff + (page_q - hit_e_q.rstart);
    case (it_q.mode)
      rtfc_pkg::ModeAdd: begin
        r.status = rtfc_pkg::StRejected;
        if (aligned && !ovl_q) begin
          if (!free_q) r.status = rtfc_pkg::StFull;
          else begin
            r.status   = rtfc_pkg::StAdded;
            r.slot_out = free_slot_q;
          end
        end
        if (add_ok) begin
          mem_we           = cmd_i.finish;
          mem_wdata.rstart = it_q.start_addr;
          mem_wdata.rend   = it_q.end_addr;
          mem_wdata.prot   = it_q.prot_in;
          mem_wdata.kind   = it_q.kind_in;
          if (it_q.kind_in == rtfc_pkg::KindFile) begin
            mem_wdata.inode = it_q.inode_in;
            mem_wdata.foff  = it_q.foff_in;
          end
          valid_d[free_slot_q] = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      rtfc_pkg::ModeRmSlot: begin
        r.status = rtfc_pkg::StNotFound;
        if (valid_q[it_q.slot]) begin
          valid_d[it_q.slot] = 1'b0;
          count_d = count_q - 1'b1;
          r.status        = rtfc_pkg::StRemoved;
          r.slot_out      = it_q.slot;
          r.removed_count = 7'd1;
        end
      end
      rtfc_pkg::ModeRmRng: begin
        valid_d         = valid_q & ~rm_mask_q;
        count_d         = count_q - rm_cnt_q;
        r.removed_count = rm_cnt_q;
        r.status = (rm_cnt_q != '0) ? rtfc_pkg::StRemoved : rtfc_pkg::StNotFound;
      end
      rtfc_pkg::ModeClear: begin
        valid_d         = '0;
        count_d         = '0;
        r.removed_count = count_q;
        r.status        = rtfc_pkg::StCleared;
      end
      rtfc_pkg::ModeFault: begin
        r.map_page = page_q;
        if (hit_q) begin
          r.slot_out = hit_slot_q;
          r.prot_out = hit_e_q.prot;
          r.kind_out = hit_e_q.kind;
          if (hit_e_q.kind == rtfc_pkg::KindGuard || (it_q.wr_access && !hit_e_q.prot[1]))
            r.status = rtfc_pkg::StUnhandled;
          else begin
            r.status = rtfc_pkg::StHandled;
            if (hit_e_q.kind == rtfc_pkg::KindFile && hit_e_q.inode != '0) begin
              r.file_inode_out = hit_e_q.inode;
              r.file_pos_out   = fpos;
            end else if (hit_e_q.kind == rtfc_pkg::KindAnon) begin
              r.prefault_count = (after < AW'(pf_limit_q)) ? after[3:0] : pf_limit_q;
            end
          end
        end else begin
          r.status = rtfc_pkg::StUnhandled;
          if (best_q) begin
            r.slot_out = best_slot_q;
            r.prot_out = best_e_q.prot;
            r.kind_out = rtfc_pkg::KindStack;
            if (page_q >= min_stack_q && grow_sz <= max_stack_q) begin
              r.status       = rtfc_pkg::StGrown;
              r.grow_pages   = 8'((best_e_q.rstart - page_q) >> PS);
              mem_we         = cmd_i.finish;
              mem_waddr      = best_slot_q;
              mem_wdata      = best_e_q;
              mem_wdata.rstart = page_q;
            end
          end
        end
      end
      default: r.status = rtfc_pkg::StUnhandled;
    endcase
    r.region_count_out = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.finish) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) res_q <= r;
  end

  assign res_o = res_q;

endmodule

// ===== design/rtfc_checker.sv =====
// ----------------------------------------------------------------------------
// rtfc_checker: port-level checks of the region table fault classifier
// One result per command, no overlap of commands, stable stalled results, bounded count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtfc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [175:0] m_axis_tdata
);

  // a command in flight blocks new input
  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  // after an input transfer no result appears in the next cycle
  `ASSERT_NEXT(a_no_instant, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    !m_axis_tvalid && !s_axis_tready)
  // a stalled result holds
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
  // region count never exceeds the table size
  `ASSERT_IMPL(a_count, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[168:162] <= 7'd64)

endmodule

bind region_table_fault_classifier rtfc_checker u_rtfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the region table fault classifier
// Drives table commands and faults over the input stream, predicts each
// result from a behavioral table model and compares every output field.
// ----------------------------------------------------------------------------
module tb;

  localparam int  TimeoutCycles = 3000000;
  localparam int  RandItems     = 1350;
  localparam int  Idle          = 80;
  localparam int  MaxErrShown   = 10;
  localparam logic [47:0] PgMask = 48'hFFF;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [47:0]  cfg_data_i = '0;

  region_table_fault_classifier uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mirrored table and configuration
  logic [47:0] tbl_start [rtfc_pkg::Entries];
  logic [47:0] tbl_end   [rtfc_pkg::Entries];
  logic [2:0]  tbl_prot  [rtfc_pkg::Entries];
  logic [1:0]  tbl_kind  [rtfc_pkg::Entries];
  logic [31:0] tbl_inode [rtfc_pkg::Entries];
  logic [47:0] tbl_foff  [rtfc_pkg::Entries];
  logic        tbl_valid [rtfc_pkg::Entries];
  int          tbl_count;
  logic [47:0] max_stack_q;
  logic [7:0]  grow_win_q;
  logic [47:0] min_stack_q;
  logic [3:0]  prefault_lim_q;

  rtfc_pkg::result_t expected_q[$];
  int      err_count, result_count, cycle_count;
  int      adds_ok, faults_ok, grows;
  int      stall_left = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TimeoutCycles) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // fault lookup: hit, stack growth or refusal
  function automatic rtfc_pkg::result_t fault_result(logic [47:0] addr, logic wr);
    rtfc_pkg::result_t r;
    logic [47:0] page, lo, win;
    logic [47:0] after;
    int hit, best;
    r = '0;
    page = addr & ~PgMask;
    r.map_page = page;
    hit = -1;
    for (int i = 0; i < rtfc_pkg::Entries; i++)
      if (hit < 0 && tbl_valid[i] && tbl_start[i] <= addr && addr < tbl_end[i]) hit = i;
    if (hit < 0) begin
      win = 48'(grow_win_q) << rtfc_pkg::PageShift;
      best = -1;
      for (int i = 0; i < rtfc_pkg::Entries; i++) begin
        if (!tbl_valid[i] || tbl_kind[i] != rtfc_pkg::KindStack) continue;
        lo = (tbl_start[i] >= win) ? tbl_start[i] - win : '0;
        if (addr >= lo && addr < tbl_start[i])
          if (best < 0 || tbl_start[i] < tbl_start[best]) best = i;
      end
      r.status = rtfc_pkg::StUnhandled;
      if (best < 0) return r;
      r.slot_out = 6'(best);
      r.prot_out = tbl_prot[best];
      r.kind_out = rtfc_pkg::KindStack;
      if (page < min_stack_q) return r;
      if (tbl_end[best] - page > max_stack_q) return r;
      r.status = rtfc_pkg::StGrown;
      r.grow_pages = 8'((tbl_start[best] - page) >> rtfc_pkg::PageShift);
      tbl_start[best] = page;
      grows++;
      return r;
    end
    r.slot_out = 6'(hit);
    r.prot_out = tbl_prot[hit];
    r.kind_out = tbl_kind[hit];
    if (tbl_kind[hit] == rtfc_pkg::KindGuard || (wr && !tbl_prot[hit][1])) begin
      r.status = rtfc_pkg::StUnhandled;
      return r;
    end
    r.status = rtfc_pkg::StHandled;
    faults_ok++;
    if (tbl_kind[hit] == rtfc_pkg::KindFile && tbl_inode[hit] != 0) begin
      r.file_inode_out = tbl_inode[hit];
      r.file_pos_out = tbl_foff[hit] + (page - tbl_start[hit]);
    end else if (tbl_kind[hit] == rtfc_pkg::KindAnon) begin
      after = (tbl_end[hit] - page) >> rtfc_pkg::PageShift;
      after = (after > 0) ? after - 48'd1 : '0;
      r.prefault_count = (after < 48'(prefault_lim_q)) ? after[3:0] : prefault_lim_q;
    end
    return r;
  endfunction

  function automatic rtfc_pkg::result_t table_result(rtfc_pkg::item_t it);
    rtfc_pkg::result_t r;
    int fs, removed;
    logic ovl;
    r = '0;
    removed = 0;
    case (it.mode)
      rtfc_pkg::ModeAdd: begin
        r.status = rtfc_pkg::StRejected;
        if ((it.start_addr & PgMask) == 0 && (it.end_addr & PgMask) == 0 &&
            it.start_addr < it.end_addr) begin
          ovl = 1'b0;
          fs = -1;
          for (int i = 0; i < rtfc_pkg::Entries; i++) begin
            if (tbl_valid[i] && it.start_addr < tbl_end[i] && tbl_start[i] < it.end_addr)
              ovl = 1'b1;
            if (!tbl_valid[i] && fs < 0) fs = i;
          end
          if (!ovl) begin
            if (fs < 0) r.status = rtfc_pkg::StFull;
            else begin
              tbl_start[fs] = it.start_addr;
              tbl_end[fs]   = it.end_addr;
              tbl_prot[fs]  = it.prot_in;
              tbl_kind[fs]  = it.kind_in;
              tbl_inode[fs] = (it.kind_in == rtfc_pkg::KindFile) ? it.inode_in : '0;
              tbl_foff[fs]  = (it.kind_in == rtfc_pkg::KindFile) ? it.foff_in : '0;
              tbl_valid[fs] = 1'b1;
              tbl_count++;
              adds_ok++;
              r.status = rtfc_pkg::StAdded;
              r.slot_out = 6'(fs);
            end
          end
        end
      end
      rtfc_pkg::ModeRmSlot: begin
        r.status = rtfc_pkg::StNotFound;
        if (tbl_valid[it.slot]) begin
          tbl_valid[it.slot] = 1'b0;
          tbl_count--;
          removed = 1;
          r.status = rtfc_pkg::StRemoved;
          r.slot_out = it.slot;
        end
      end
      rtfc_pkg::ModeRmRng: begin
        for (int i = 0; i < rtfc_pkg::Entries; i++)
          if (tbl_valid[i] && tbl_start[i] < it.end_addr && it.start_addr < tbl_end[i]) begin
            tbl_valid[i] = 1'b0;
            tbl_count--;
            removed++;
          end
        r.status = (removed != 0) ? rtfc_pkg::StRemoved : rtfc_pkg::StNotFound;
      end
      rtfc_pkg::ModeClear: begin
        for (int i = 0; i < rtfc_pkg::Entries; i++) begin
          if (tbl_valid[i]) removed++;
          tbl_valid[i] = 1'b0;
        end
        tbl_count = 0;
        r.status = rtfc_pkg::StCleared;
      end
      rtfc_pkg::ModeFault: r = fault_result(it.flt_addr, it.wr_access);
      default: r.status = rtfc_pkg::StUnhandled;
    endcase
    r.removed_count = 7'(removed);
    r.region_count_out = 7'(tbl_count);
    return r;
  endfunction

  // one input transfer; prediction made at acceptance
  task automatic send_item(rtfc_pkg::item_t it);
    repeat (gap_len()) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.wr_access, it.flt_addr, it.slot, it.foff_in,
                      it.inode_in, it.kind_in, it.prot_in, it.end_addr, it.start_addr,
                      it.mode};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(table_result(it));
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Idle) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rtfc_pkg::CfgMaxStack: max_stack_q    = val;
      rtfc_pkg::CfgGrowPg:   grow_win_q     = val[7:0];
      rtfc_pkg::CfgMinStack: min_stack_q    = val;
      default:               prefault_lim_q = val[3:0];
    endcase
    @(posedge clk_i);
  endtask

  // result receiver with random stalls
  always @(posedge clk_i) begin
    rtfc_pkg::result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = rtfc_pkg::result_t'({m_axis_tdata[0 +: 4], m_axis_tdata[4 +: 6],
                       m_axis_tdata[10 +: 48],
                       m_axis_tdata[58 +: 3], m_axis_tdata[61 +: 2], m_axis_tdata[63 +: 32],
                       m_axis_tdata[95 +: 48], m_axis_tdata[143 +: 8],
                       m_axis_tdata[151 +: 4], m_axis_tdata[155 +: 7],
                       m_axis_tdata[162 +: 7]});
      result_count++;
      if (expected_q.size() == 0) begin
        err_count++;
        if (err_count <= MaxErrShown) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= MaxErrShown)
            $display("result %0d mismatch\n  exp %p\n  got %p", result_count, want, got);
        end
      end
    end
    // ready low for a random stretch, mostly short, sometimes long
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall_left = gap_len();
      m_axis_tready <= (stall_left == 0);
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  function automatic rtfc_pkg::item_t blank_item();
    rtfc_pkg::item_t it;
    it = '0;
    it.start_addr = rand48(); it.end_addr = rand48(); it.inode_in = $urandom();
    it.foff_in = rand48(); it.slot = 6'($urandom()); it.flt_addr = rand48();
    it.prot_in = 3'($urandom()); it.wr_access = 1'($urandom());
    return it;
  endfunction

  task automatic add_region(logic [47:0] s, logic [47:0] e, logic [2:0] p, logic [1:0] k);
    rtfc_pkg::item_t it;
    it = blank_item();
    it.mode = rtfc_pkg::ModeAdd; it.start_addr = s; it.end_addr = e; it.prot_in = p;
    it.kind_in = k;
    send_item(it);
  endtask

  task automatic fault_at(logic [47:0] a, logic wr);
    rtfc_pkg::item_t it;
    it = blank_item();
    it.mode = rtfc_pkg::ModeFault; it.flt_addr = a; it.wr_access = wr;
    send_item(it);
  endtask

  task automatic test_directed();
    rtfc_pkg::item_t it;
    add_region(48'h1000, 48'h1000, 3'd3, rtfc_pkg::KindAnon);        // empty range
    add_region(48'h1001, 48'h3000, 3'd3, rtfc_pkg::KindAnon);        // misaligned
    add_region(48'h10000, 48'h20000, 3'd1, rtfc_pkg::KindAnon);      // read-only anon
    add_region(48'h18000, 48'h30000, 3'd3, rtfc_pkg::KindAnon);      // overlap
    add_region(48'h40000, 48'h50000, 3'd3, rtfc_pkg::KindFile);
    add_region(48'h60000, 48'h61000, 3'd7, rtfc_pkg::KindGuard);
    add_region(48'h80000, 48'h90000, 3'd3, rtfc_pkg::KindStack);
    add_region(48'hFFFF_FFFF_E000, 48'hFFFF_FFFF_F000, 3'd7, rtfc_pkg::KindAnon);
    fault_at(48'h1F123, 1'b0);
    fault_at(48'h10000, 1'b1);                              // write to read-only
    fault_at(48'h4A010, 1'b1);
    fault_at(48'h60800, 1'b0);                              // guard
    fault_at(48'h7F000, 1'b1);                              // stack growth
    fault_at(48'h6F000, 1'b0);                              // grows the stack again
    fault_at(48'h0, 1'b0);
    fault_at(48'hFFFF_FFFF_EFFF, 1'b0);
    it = blank_item(); it.mode = rtfc_pkg::ModeRmSlot; it.slot = 6'd63; send_item(it);
    it = blank_item(); it.mode = rtfc_pkg::ModeRmSlot; it.slot = 6'd0;  send_item(it);
    it = blank_item(); it.mode = rtfc_pkg::ModeRmRng;
    it.start_addr = 48'h45000; it.end_addr = 48'h62000; send_item(it);
    it = blank_item(); it.mode = 3'd5; send_item(it);
    it = blank_item(); it.mode = 3'd7; send_item(it);
    it = blank_item(); it.mode = rtfc_pkg::ModeClear; send_item(it);
    wait_drained();
  endtask

  // fill to capacity, then table full
  task automatic test_full_table();
    for (int i = 0; i < rtfc_pkg::Entries + 1; i++)
      add_region(48'(i) << 16, (48'(i) << 16) + 48'h2000, 3'($urandom()), 2'($urandom()));
    fault_at(48'h3F_1000, 1'b0);
    begin
      rtfc_pkg::item_t it;
      it = blank_item(); it.mode = rtfc_pkg::ModeClear; send_item(it);
    end
    wait_drained();
  endtask

  // random scenario under one configuration
  task automatic test_random(int n);
    rtfc_pkg::item_t it;
    logic [47:0] base, a;
    int r;
    for (int k = 0; k < n; k++) begin
      it = blank_item();
      r = $urandom_range(0, 99);
      base = 48'($urandom_range(0, 255)) << 16;
      if ($urandom_range(0, 19) == 0) base = rand48() & ~PgMask;
      it.kind_in = 2'($urandom());
      if (r < 30) begin
        it.mode = rtfc_pkg::ModeAdd;
        it.start_addr = base;
        it.end_addr = base + (48'($urandom_range(1, 20)) << 12);
        if ($urandom_range(0, 9) == 0) it.end_addr = rand48();
      end else if (r < 37) begin
        it.mode = rtfc_pkg::ModeRmSlot;
      end else if (r < 42) begin
        it.mode = rtfc_pkg::ModeRmRng;
        it.start_addr = base;
        it.end_addr = base + 48'($urandom_range(1, 200000));
      end else if (r < 44) begin
        it.mode = rtfc_pkg::ModeClear;
      end else if (r < 98) begin
        it.mode = rtfc_pkg::ModeFault;
        a = base + 48'($urandom_range(0, 24'h1FFFF));
        if ($urandom_range(0, 3) == 0) a = base - 48'($urandom_range(1, 24'h120000));
        if ($urandom_range(0, 19) == 0) a = rand48();
        it.flt_addr = a;
      end else begin
        it.mode = 3'($urandom_range(5, 7));
      end
      send_item(it);
      if (k == n / 2) wait_drained();   // hold off until all results are back
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < rtfc_pkg::Entries; i++) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    max_stack_q = 48'd8388608; grow_win_q = 8'd16; min_stack_q = 48'd4096;
    prefault_lim_q = 4'd4;
    err_count = 0; result_count = 0; cycle_count = 0;
    adds_ok = 0; faults_ok = 0; grows = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random(400);
    write_cfg(rtfc_pkg::CfgMaxStack, 48'hFFFF_FFFF_FFFF);
    write_cfg(rtfc_pkg::CfgGrowPg, 48'd255);
    write_cfg(rtfc_pkg::CfgMinStack, 48'd0);
    write_cfg(rtfc_pkg::CfgPrefault, 48'd15);
    test_random(350);
    write_cfg(rtfc_pkg::CfgMaxStack, 48'd0);
    write_cfg(rtfc_pkg::CfgGrowPg, 48'd0);
    write_cfg(rtfc_pkg::CfgMinStack, 48'hFFFF_FFFF_FFFF);
    write_cfg(rtfc_pkg::CfgPrefault, 48'd0);
    test_random(200);
    write_cfg(rtfc_pkg::CfgMaxStack, 48'h20000);
    write_cfg(rtfc_pkg::CfgGrowPg, 48'd40);
    write_cfg(rtfc_pkg::CfgMinStack, 48'h30000);
    write_cfg(rtfc_pkg::CfgPrefault, 48'd7);
    test_random(400);
    $display("covered %0d results: %0d adds, %0d handled faults, %0d stack growths",
             result_count, adds_ok, faults_ok, grows);
    $display("four configuration settings, extremes included; %0d mismatches", err_count);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
